// ===== rtl/swt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_pkg
// Token kinds, token and bundle types shared by the shell word tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam logic [2:0] KIND_BYTE   = 3'd0;
  localparam logic [2:0] KIND_WEND   = 3'd1;
  localparam logic [2:0] KIND_EOS    = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_OTHER  = 3'd4;
  localparam logic [2:0] KIND_UNTERM = 3'd5;
  localparam logic [2:0] KIND_BADESC = 3'd6;

  // Most tokens a single text byte can cause.
  localparam int MAX_TOKENS = 4;
  localparam int TOK_IDX_W  = 2;
  localparam int TOK_CNT_W  = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } token_t;

  // All tokens caused by one text byte.
  typedef struct packed {
    logic [TOK_CNT_W-1:0]        count;
    token_t [MAX_TOKENS-1:0]     toks;
  } bundle_t;

  // Append one token to a bundle; ignore it once the bundle is full.
  function automatic bundle_t add_token(bundle_t b, logic [2:0] kind, logic [7:0] value);
    bundle_t r;
    r = b;
    if (b.count < TOK_CNT_W'(MAX_TOKENS)) begin
      r.toks[b.count[TOK_IDX_W-1:0]].kind  = kind;
      r.toks[b.count[TOK_IDX_W-1:0]].value = value;
      r.count = b.count + TOK_CNT_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/swt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_front
// Scan-mode state machine: classify each text byte into a token bundle.
// ----------------------------------------------------------------------------
module swt_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_text_byte,
  output logic             push_valid,
  output swt_pkg::bundle_t push_data,
  input  logic             q_full
);
  import swt_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_WORD    = 3'd1,
    MODE_SQUOTE  = 3'd2,
    MODE_DQUOTE  = 3'd3,
    MODE_ESCAPE  = 3'd4,
    MODE_OCTAL   = 3'd5,
    MODE_HEX     = 3'd6,
    MODE_COMMENT = 3'd7
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] dig_r, dig_nxt;

  logic [7:0] c;
  logic       is_print, is_oct, is_hex;
  logic [3:0] hex_val;
  logic [7:0] oct_acc, hex_acc;
  logic [1:0] dig_inc;
  logic       redq, reidle;
  logic       take;
  bundle_t    b;

  assign c        = in_text_byte;
  assign is_print = (c >= 8'h21) && (c <= 8'h7e);
  assign is_oct   = (c >= 8'h30) && (c <= 8'h37);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = c[3:0];
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      hex_val = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  assign oct_acc = {acc_r[4:0], 3'b000} | {5'b00000, c[2:0]};
  assign hex_acc = {acc_r[3:0], hex_val};
  assign dig_inc = dig_r + 2'd1;

  always_comb begin
    b        = '0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    redq     = 1'b0;
    reidle   = 1'b0;

    case (mode_r)
      MODE_IDLE: reidle = 1'b1;
      MODE_WORD: begin
        if (is_print && (c != CH_HASH) && (c != CH_SEMI)) begin
          b = add_token(b, KIND_BYTE, c);
        end else begin
          b      = add_token(b, KIND_WEND, 8'h00);
          reidle = 1'b1;
        end
      end
      MODE_SQUOTE: begin
        if (c == CH_NUL) begin
          b      = add_token(b, KIND_UNTERM, 8'h00);
          b      = add_token(b, KIND_WEND, 8'h00);
          reidle = 1'b1;
        end else if (c == CH_SQ) begin
          b        = add_token(b, KIND_WEND, 8'h00);
          mode_nxt = MODE_IDLE;
        end else begin
          b = add_token(b, KIND_BYTE, c);
        end
      end
      MODE_DQUOTE: redq = 1'b1;
      MODE_ESCAPE: begin
        mode_nxt = MODE_DQUOTE;
        if (c == 8'h61) begin
          b = add_token(b, KIND_BYTE, 8'h07);
        end else if (c == 8'h62) begin
          b = add_token(b, KIND_BYTE, 8'h08);
        end else if (c == 8'h65) begin
          b = add_token(b, KIND_BYTE, 8'h1b);
        end else if (c == 8'h66) begin
          b = add_token(b, KIND_BYTE, 8'h0c);
        end else if (c == 8'h72) begin
          b = add_token(b, KIND_BYTE, 8'h0d);
        end else if (c == 8'h76) begin
          b = add_token(b, KIND_BYTE, 8'h0b);
        end else if (c inside {CH_DQ, CH_SQ, CH_BSLASH}) begin
          b = add_token(b, KIND_BYTE, c);
        end else if (c == 8'h78) begin
          acc_nxt  = 8'h00;
          dig_nxt  = 2'd0;
          mode_nxt = MODE_HEX;
        end else if (c == CH_NUL) begin
          redq = 1'b1;
        end else if (is_oct) begin
          acc_nxt  = {5'b00000, c[2:0]};
          dig_nxt  = 2'd1;
          mode_nxt = MODE_OCTAL;
        end else begin
          b = add_token(b, KIND_BADESC, 8'h00);
        end
      end
      MODE_OCTAL: begin
        if (is_oct) begin
          acc_nxt = oct_acc;
          dig_nxt = dig_inc;
          if ((dig_inc == 2'd3) || (dig_inc == 2'd0)) begin
            b        = add_token(b, KIND_BYTE, oct_acc);
            acc_nxt  = 8'h00;
            dig_nxt  = 2'd0;
            mode_nxt = MODE_DQUOTE;
          end
        end else begin
          b       = add_token(b, KIND_BYTE, acc_r);
          acc_nxt = 8'h00;
          dig_nxt = 2'd0;
          redq    = 1'b1;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          acc_nxt = hex_acc;
          dig_nxt = dig_inc;
          if ((dig_inc >= 2'd2) || (dig_inc == 2'd0)) begin
            b        = add_token(b, KIND_BYTE, hex_acc);
            acc_nxt  = 8'h00;
            dig_nxt  = 2'd0;
            mode_nxt = MODE_DQUOTE;
          end
        end else begin
          b       = add_token(b, KIND_BYTE, acc_r);
          acc_nxt = 8'h00;
          dig_nxt = 2'd0;
          redq    = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if ((c == CH_NL) || (c == CH_NUL)) begin
          reidle = 1'b1;
        end
      end
      default: reidle = 1'b1;
    endcase

    // Re-read the byte in double-quote mode.
    if (redq) begin
      mode_nxt = MODE_DQUOTE;
      if (c == CH_NUL) begin
        b      = add_token(b, KIND_UNTERM, 8'h00);
        b      = add_token(b, KIND_WEND, 8'h00);
        reidle = 1'b1;
      end else if (c == CH_DQ) begin
        b        = add_token(b, KIND_WEND, 8'h00);
        mode_nxt = MODE_IDLE;
      end else if (c == CH_BSLASH) begin
        mode_nxt = MODE_ESCAPE;
      end else begin
        b = add_token(b, KIND_BYTE, c);
      end
    end

    // Re-read the byte in idle mode.
    if (reidle) begin
      mode_nxt = MODE_IDLE;
      if (c == CH_NUL) begin
        b = add_token(b, KIND_EOF, 8'h00);
      end else if (c inside {CH_NL, CH_CR, CH_SEMI}) begin
        b = add_token(b, KIND_EOS, 8'h00);
      end else if (c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF}) begin
        mode_nxt = MODE_IDLE;
      end else if (c == CH_HASH) begin
        mode_nxt = MODE_COMMENT;
      end else if (c == CH_SQ) begin
        mode_nxt = MODE_SQUOTE;
      end else if (c == CH_DQ) begin
        mode_nxt = MODE_DQUOTE;
      end else if (is_print) begin
        b        = add_token(b, KIND_BYTE, c);
        mode_nxt = MODE_WORD;
      end else begin
        b = add_token(b, KIND_OTHER, c);
      end
    end
  end

  assign in_ready   = !q_full;
  assign take       = in_valid && in_ready;
  assign push_valid = take && (b.count != '0);
  assign push_data  = b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= 8'h00;
      dig_r  <= 2'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
    end
  end

endmodule

// ===== rtl/swt_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_queue
// Short queue of token bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module swt_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  swt_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output swt_pkg::bundle_t head_data
);
  import swt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/swt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_back
// Output stage: walk the head bundle one token per transaction.
// ----------------------------------------------------------------------------
module swt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  swt_pkg::bundle_t head_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_token_kind,
  output logic [7:0]       out_token_value,
  output logic             out_run_last
);
  import swt_pkg::*;

  logic [TOK_IDX_W-1:0] idx_r, idx_nxt;
  logic                 last;
  logic                 fire;

  assign last            = ({1'b0, idx_r} == (head_data.count - TOK_CNT_W'(1)));
  assign out_valid       = head_valid;
  assign out_token_kind  = head_data.toks[idx_r].kind;
  assign out_token_value = head_data.toks[idx_r].value;
  assign out_run_last    = last;
  assign fire            = out_valid && out_ready;
  assign pop             = fire && last;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = last ? '0 : idx_r + TOK_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/shell_word_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_word_tokenizer
// Shell command text lexer with backslash escape decoding in double quotes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / in_text_byte) takes one text byte
//   per transaction; byte 0 ends the text. Result channel (out_valid /
//   out_ready / out_token_kind / out_token_value / out_run_last) returns the
//   tokens each byte causes, zero to four of them, with out_run_last set on
//   the final token of a byte.
//   A byte's bundle is registered in the queue before its first token
//   appears on the output.
//   Throughput: one byte per cycle while the queue is not full, limited by
//   the scan-mode register update. A byte that causes k tokens occupies the
//   output for k transactions; a byte that causes none pushes no bundle.
//   The scanner and the output stage are parted by a queue of QUEUE_DEPTH
//   token bundles. When the receiver stalls, the queue fills and in_ready
//   falls once it is full; the scanner keeps its mode meanwhile.
//   Reset: synchronous, active low. Scan mode returns to idle, the escape
//   accumulator and digit count clear, and the queue empties.
// ----------------------------------------------------------------------------
module shell_word_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_token_value,
  output logic       out_run_last
);
  import swt_pkg::*;

  // Front to queue.
  logic    push_valid;
  bundle_t push_data;
  logic    q_full;

  // Queue to back.
  logic    head_valid;
  bundle_t head_data;
  logic    pop;

  // Classify each byte and build its token bundle.
  swt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .push_valid   (push_valid),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  // Hold bundles so the scanner runs ahead of a stalled receiver.
  swt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Serialize the head bundle, one token per transaction.
  swt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_run_last    (out_run_last)
  );

  // Only word bytes and other-char tokens carry a value.
  a_value_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind != KIND_BYTE) && (out_token_kind != KIND_OTHER))
      |-> (out_token_value == 8'h00))
    else $error("token value nonzero for a kind without value");

  // End of input always closes the run of its byte.
  a_eof_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == KIND_EOF)) |-> out_run_last)
    else $error("end input token not last of its byte");

  // An unterminated report is always followed by a word end of the same byte.
  a_unterm_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == KIND_UNTERM)) |-> !out_run_last)
    else $error("unterminated token closes its run");

  // Nothing comes out right after reset.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
